/* rtl/tlp_pkg.sv */
// ---------------------------------------------------------------------------
// tlp_pkg: shared types and constants of the tick line parser
// Character codes, status codes and the line snapshot passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none
package tlp_pkg;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_NONPOS  = 2'd2;
  localparam logic [1:0] ST_CROSSED = 2'd3;

  localparam int PW = 48;
  localparam logic [PW-1:0] PRICE_MAX = 48'h7FFF_FFFF_FFFF;

  typedef logic [PW-1:0] price_t;

  typedef struct packed {
    logic        few;
    logic [31:0] line_number;
    logic [13:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [15:0] hh;
    logic [15:0] mm;
    logic [15:0] ss;
    logic [15:0] ms;
    price_t      bid;
    price_t      ask;
    price_t      last;
    price_t      volume;
    logic [31:0] flags;
  } snap_t;

  // 10^n for n in 0..9
  function automatic logic [51:0] pow10(input logic [3:0] n);
    logic [51:0] r;
    unique case (n)
      4'd0: r = 52'd1;
      4'd1: r = 52'd10;
      4'd2: r = 52'd100;
      4'd3: r = 52'd1000;
      4'd4: r = 52'd10000;
      4'd5: r = 52'd100000;
      4'd6: r = 52'd1000000;
      4'd7: r = 52'd10000000;
      4'd8: r = 52'd100000000;
      4'd9: r = 52'd1000000000;
      default: r = 52'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/tlp_if.sv */
// ---------------------------------------------------------------------------
// tlp_if: channel interfaces of the tick line parser
// Byte input channel and line result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface tlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface tlp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        line_number;
  logic [13:0]        year;
  logic [7:0]         month;
  logic [7:0]         day;
  logic [37:0]        time_ms;
  logic signed [47:0] bid;
  logic signed [47:0] ask;
  logic signed [47:0] last;
  logic signed [47:0] volume;
  logic [31:0]        flags;
  modport source (output valid, output status, output line_number, output year,
                  output month, output day, output time_ms, output bid, output ask,
                  output last, output volume, output flags, input ready);
  modport sink   (input valid, input status, input line_number, input year,
                  input month, input day, input time_ms, input bid, input ask,
                  input last, input volume, input flags, output ready);
endinterface
`default_nettype wire

/* rtl/tlp_parser.sv */
// ---------------------------------------------------------------------------
// tlp_parser: byte register and running column accumulators
// Updates line state one byte a cycle, but a line end waits on a full snapshot register; one snapshot per data line.
// ---------------------------------------------------------------------------
`default_nettype none
module tlp_parser #(
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_ch,
  output logic              snap_valid,
  input  wire logic         snap_ready,
  output tlp_pkg::snap_t    snap
);
  import tlp_pkg::*;

  localparam logic [51:0] P_INT = pow10(4'(FRAC_DIGITS));
  localparam logic [3:0]  FD    = 4'(FRAC_DIGITS);

  logic        s0_v_r;
  logic [7:0]  s0_ch_r;
  logic [31:0] line_cnt_r, line_cnt_nxt;
  logic        at_start_r, at_start_nxt;
  logic        skip_r, skip_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] dt_r [7];
  logic [15:0] dt_nxt [7];
  logic [15:0] dt_e [7];
  logic [1:0]  sep_r, sep_nxt;
  price_t      acc_r [4];
  price_t      acc_nxt [4];
  price_t      acc_e [4];
  logic        neg_r, neg_nxt;
  logic [3:0]  fds_r, fds_nxt;
  logic        inf_r, inf_nxt;
  logic [31:0] flg_r, flg_nxt;
  logic        emit, fire0;
  snap_t       snap_r, snap_nxt;
  logic        snap_v_r;

  logic        is_dig;
  logic [3:0]  dig;
  logic [2:0]  pidx;
  logic [1:0]  aidx;
  logic [15:0] part;
  logic [19:0] pv;
  logic [19:0] cap;
  logic [51:0] pt;
  logic [3:0]  fds_inc;
  logic [35:0] fv;

  assign is_dig = (s0_ch_r >= CH_ZERO) && (s0_ch_r <= CH_NINE);
  assign dig    = 4'(s0_ch_r - CH_ZERO);
  assign aidx   = 2'(col_r - 3'd2);
  assign fds_inc = fds_r + 4'd1;

  // column end: drop date/time without both separators, apply price sign
  always_comb begin
    for (int i = 0; i < 7; i++) dt_e[i] = dt_r[i];
    for (int i = 0; i < 4; i++) acc_e[i] = acc_r[i];
    if (col_r == 3'd0 && sep_r < 2'd2) begin
      for (int i = 0; i < 3; i++) dt_e[i] = '0;
    end
    if (col_r == 3'd1 && sep_r < 2'd2) begin
      for (int i = 3; i < 7; i++) dt_e[i] = '0;
    end
    if (col_r >= 3'd2 && col_r <= 3'd5 && neg_r) begin
      acc_e[aidx] = '0 - acc_r[aidx];
    end
  end

  always_comb begin
    line_cnt_nxt = line_cnt_r;
    at_start_nxt = at_start_r;
    skip_nxt     = skip_r;
    col_nxt      = col_r;
    sub_nxt      = sub_r;
    stop_nxt     = stop_r;
    sep_nxt      = sep_r;
    neg_nxt      = neg_r;
    fds_nxt      = fds_r;
    inf_nxt      = inf_r;
    flg_nxt      = flg_r;
    for (int i = 0; i < 7; i++) dt_nxt[i] = dt_r[i];
    for (int i = 0; i < 4; i++) acc_nxt[i] = acc_r[i];
    emit = 1'b0;
    pidx = (col_r == 3'd0) ? {1'b0, sub_r} : 3'(3'd3 + {1'b0, sub_r});
    part = dt_r[pidx];
    pv   = {part, 3'b000} + {2'b00, part, 1'b0} + {16'd0, dig};
    cap  = (col_r == 3'd1) ? 20'd65535 : ((sub_r == 2'd0) ? 20'd9999 : 20'd255);
    if (!inf_r) begin
      pt = {acc_r[aidx], 3'b000} + {3'b000, acc_r[aidx], 1'b0} + 52'(dig) * P_INT;
    end else begin
      pt = {4'd0, acc_r[aidx]} + 52'(dig) * pow10(FD - fds_inc);
    end
    fv = {1'b0, flg_r, 3'b000} + {3'b000, flg_r, 1'b0} + {32'd0, dig};

    snap_nxt.few         = (col_r < 3'd3);
    snap_nxt.line_number = line_cnt_r + 32'd1;
    snap_nxt.year        = dt_e[0][13:0];
    snap_nxt.month       = dt_e[1][7:0];
    snap_nxt.day         = dt_e[2][7:0];
    snap_nxt.hh          = dt_e[3];
    snap_nxt.mm          = dt_e[4];
    snap_nxt.ss          = dt_e[5];
    snap_nxt.ms          = dt_e[6];
    snap_nxt.bid         = acc_e[0];
    snap_nxt.ask         = acc_e[1];
    snap_nxt.last        = acc_e[2];
    snap_nxt.volume      = acc_e[3];
    snap_nxt.flags       = flg_r;

    if (s0_ch_r != CH_NL) begin
      at_start_nxt = 1'b0;
      skip_nxt     = skip_r | (at_start_r && s0_ch_r == CH_LT);
      if (!skip_nxt) begin
        if (s0_ch_r == CH_TAB) begin
          for (int i = 0; i < 7; i++) dt_nxt[i] = dt_e[i];
          for (int i = 0; i < 4; i++) acc_nxt[i] = acc_e[i];
          sub_nxt = '0; stop_nxt = 1'b0; sep_nxt = '0;
          neg_nxt = 1'b0; fds_nxt = '0; inf_nxt = 1'b0;
          if (col_r < 3'd7) col_nxt = col_r + 3'd1;
        end else begin
          priority case (col_r)
            3'd0: begin
              if (s0_ch_r == CH_DOT && sub_r < 2'd2) begin
                sub_nxt = sub_r + 2'd1; sep_nxt = sep_r + 2'd1; stop_nxt = 1'b0;
              end else if (!stop_r) begin
                if (is_dig) dt_nxt[pidx] = (pv > cap) ? cap[15:0] : pv[15:0];
                else stop_nxt = 1'b1;
              end
            end
            3'd1: begin
              if (s0_ch_r == CH_COLON && sub_r < 2'd2) begin
                sub_nxt = sub_r + 2'd1; sep_nxt = sep_r + 2'd1; stop_nxt = 1'b0;
              end else if (s0_ch_r == CH_DOT && sub_r == 2'd2) begin
                sub_nxt = 2'd3; stop_nxt = 1'b0;
              end else if (!stop_r) begin
                if (is_dig) dt_nxt[pidx] = (pv > cap) ? cap[15:0] : pv[15:0];
                else stop_nxt = 1'b1;
              end
            end
            3'd2, 3'd3, 3'd4, 3'd5: begin
              if (!stop_r) begin
                sub_nxt = 2'd1;
                if (s0_ch_r == CH_MINUS && sub_r == 2'd0) begin
                  neg_nxt = 1'b1;
                end else if (is_dig) begin
                  if (!inf_r || fds_r < FD) begin
                    if (inf_r) fds_nxt = fds_inc;
                    acc_nxt[aidx] = (pt > 52'(PRICE_MAX)) ? PRICE_MAX : pt[PW-1:0];
                  end
                end else if (s0_ch_r == CH_DOT && !inf_r) begin
                  inf_nxt = 1'b1;
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end
            3'd6: begin
              if (!stop_r) begin
                if (is_dig) flg_nxt = (|fv[35:32]) ? 32'hFFFF_FFFF : fv[31:0];
                else stop_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end else begin
      line_cnt_nxt = line_cnt_r + 32'd1;
      emit         = !(at_start_r || skip_r);
      at_start_nxt = 1'b1;
      skip_nxt     = 1'b0;
      col_nxt = '0; sub_nxt = '0; stop_nxt = 1'b0; sep_nxt = '0;
      neg_nxt = 1'b0; fds_nxt = '0; inf_nxt = 1'b0; flg_nxt = '0;
      for (int i = 0; i < 7; i++) dt_nxt[i] = '0;
      for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
    end
  end

  assign fire0    = s0_v_r && (!emit || !snap_v_r || snap_ready);
  assign in_ready = !s0_v_r || fire0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      snap_v_r   <= 1'b0;
      line_cnt_r <= '0;
      at_start_r <= 1'b1;
      skip_r     <= 1'b0;
      col_r      <= '0;
      sub_r      <= '0;
      stop_r     <= 1'b0;
      sep_r      <= '0;
      neg_r      <= 1'b0;
      fds_r      <= '0;
      inf_r      <= 1'b0;
      flg_r      <= '0;
      for (int i = 0; i < 7; i++) dt_r[i] <= '0;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else begin
      if (in_ready) s0_v_r <= in_valid;
      if (fire0 && emit) snap_v_r <= 1'b1;
      else if (snap_ready) snap_v_r <= 1'b0;
      if (fire0) begin
        line_cnt_r <= line_cnt_nxt;
        at_start_r <= at_start_nxt;
        skip_r     <= skip_nxt;
        col_r      <= col_nxt;
        sub_r      <= sub_nxt;
        stop_r     <= stop_nxt;
        sep_r      <= sep_nxt;
        neg_r      <= neg_nxt;
        fds_r      <= fds_nxt;
        inf_r      <= inf_nxt;
        flg_r      <= flg_nxt;
        for (int i = 0; i < 7; i++) dt_r[i] <= dt_nxt[i];
        for (int i = 0; i < 4; i++) acc_r[i] <= acc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s0_ch_r <= in_ch;
    if (fire0 && emit) snap_r <= snap_nxt;
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule
`default_nettype wire

/* rtl/tlp_finish.sv */
// ---------------------------------------------------------------------------
// tlp_finish: line result stages
// Time of day in two multiply stages, status from column count and bid/ask, result register.
// ---------------------------------------------------------------------------
`default_nettype none
module tlp_finish (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         snap_valid,
  output logic              snap_ready,
  input  wire tlp_pkg::snap_t snap,
  tlp_out_if.source         out_chan
);
  import tlp_pkg::*;

  logic        s2_v_r, s3_v_r;
  snap_t       s2_r;
  logic [28:0] sec_r, sec_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        rdy2, rdy3;
  logic [38:0] tms;
  logic signed [47:0] b, a;

  assign b = signed'(snap.bid);
  assign a = signed'(snap.ask);

  always_comb begin
    sec_nxt = 29'(snap.hh) * 29'd3600 + 29'(snap.mm) * 29'd60 + 29'(snap.ss);
    if (snap.few) st_nxt = ST_FEW;
    else if (b <= 48'sd0 || a <= 48'sd0) st_nxt = ST_NONPOS;
    else if (b > a) st_nxt = ST_CROSSED;
    else st_nxt = ST_OK;
  end

  assign tms = 39'(sec_r) * 39'd1000 + 39'(s2_r.ms);

  assign rdy3       = !s3_v_r || out_chan.ready;
  assign rdy2       = !s2_v_r || rdy3;
  assign snap_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy2) s2_v_r <= snap_valid;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && snap_valid) begin
      s2_r  <= snap;
      sec_r <= sec_nxt;
      st_r  <= st_nxt;
    end
    if (rdy3 && s2_v_r) begin
      out_chan.status      <= st_r;
      out_chan.line_number <= s2_r.line_number;
      if (s2_r.few) begin
        out_chan.year    <= '0;
        out_chan.month   <= '0;
        out_chan.day     <= '0;
        out_chan.time_ms <= '0;
        out_chan.bid     <= '0;
        out_chan.ask     <= '0;
        out_chan.last    <= '0;
        out_chan.volume  <= '0;
        out_chan.flags   <= '0;
      end else begin
        out_chan.year    <= s2_r.year;
        out_chan.month   <= s2_r.month;
        out_chan.day     <= s2_r.day;
        out_chan.time_ms <= tms[37:0];
        out_chan.bid     <= signed'(s2_r.bid);
        out_chan.ask     <= signed'(s2_r.ask);
        out_chan.last    <= signed'(s2_r.last);
        out_chan.volume  <= signed'(s2_r.volume);
        out_chan.flags   <= s2_r.flags;
      end
    end
  end

  assign out_chan.valid = s3_v_r;

endmodule
`default_nettype wire

/* rtl/tick_line_parser.sv */
// ---------------------------------------------------------------------------
// tick_line_parser: streaming parser for tab-separated tick text
// One byte per item in, one result per data line out.
// ---------------------------------------------------------------------------
// Takes one text byte per cycle unless a line end finds the snapshot
// register full and not taken; each byte only updates running per-column
// accumulators in the parser stage. A newline that ends a data line hands
// a snapshot to two finishing stages (hour/minute/second scaling and
// status, then the millisecond multiply), which register it in turn. Empty
// lines and lines starting with '<' are counted but give no result. Both
// channels are valid/ready; each stage holds one item, so input keeps
// flowing while a result waits on the output.
`default_nettype none
module tick_line_parser #(
  parameter int FRAC_DIGITS = 6   // fraction digits kept in prices, 1..9
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tlp_in_if.sink    in_chan,
  tlp_out_if.source out_chan
);
  import tlp_pkg::*;

  snap_t snap;
  logic  snap_valid, snap_ready;

  // byte stage and column accumulators
  tlp_parser #(.FRAC_DIGITS(FRAC_DIGITS)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_ch      (in_chan.ch),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // time scaling, status, result register
  tlp_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb: testbench of the tick line parser
// Drives tick text one byte at a time with random gaps and output stalls,
// predicts each line result and compares every field of every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import tlp_pkg::*;

  localparam int FRAC = 6;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned LIMIT = 64'd2000000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] line_number;
    logic [13:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [37:0] time_ms;
    logic [47:0] bid;
    logic [47:0] ask;
    logic [47:0] last;
    logic [47:0] volume;
    logic [31:0] flags;
  } line_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  tlp_in_if  in_chan ();
  tlp_out_if out_chan ();

  tick_line_parser #(.FRAC_DIGITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  // Predictor state: a copy of the parser's running accumulators.
  logic [31:0]     p_lines;
  bit              p_start, p_skip, p_stop, p_neg, p_frac;
  int unsigned     p_col, p_sub, p_sep, p_fdig;
  int unsigned     p_parts [7];
  longint unsigned p_acc [4];
  longint unsigned p_flags;

  line_res_t   lines_due [$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit          sending_done = 1'b0;

  function automatic bit is_dig(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint unsigned ten_to(int unsigned n);
    longint unsigned r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  task automatic clear_col();
    p_sub = 0; p_stop = 0; p_sep = 0; p_neg = 0; p_fdig = 0; p_frac = 0;
  endtask

  task automatic clear_ln();
    clear_col();
    p_col = 0;
    foreach (p_parts[i]) p_parts[i] = 0;
    foreach (p_acc[i]) p_acc[i] = 0;
    p_flags = 0;
  endtask

  task automatic pred_reset();
    p_lines = 0; p_start = 1; p_skip = 0;
    clear_ln();
  endtask

  task automatic add_digit(int k, logic [7:0] c, int unsigned cap);
    int unsigned v;
    v = p_parts[k] * 10 + (c - CH_ZERO);
    p_parts[k] = (v > cap) ? cap : v;
  endtask

  function automatic longint unsigned sat47(longint unsigned v);
    return (v > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : v;
  endfunction

  task automatic close_col();
    if (p_col == 0 && p_sep < 2) for (int i = 0; i < 3; i++) p_parts[i] = 0;
    if (p_col == 1 && p_sep < 2) for (int i = 3; i < 7; i++) p_parts[i] = 0;
    if (p_col >= 2 && p_col <= 5 && p_neg) p_acc[p_col-2] = (0 - p_acc[p_col-2]) & MASK48;
    clear_col();
  endtask

  // Advance the predictor by one byte; queue a result when a data line ends.
  task automatic parse_byte(logic [7:0] c);
    line_res_t r;
    longint signed b, a;
    int k;
    if (c != CH_NL) begin
      if (p_start && c == CH_LT) p_skip = 1;
      p_start = 0;
      if (p_skip) return;
      if (c == CH_TAB) begin
        close_col();
        if (p_col < 7) p_col++;
        return;
      end
      case (p_col)
        0: begin
          if (c == CH_DOT && p_sub < 2) begin
            p_sub++; p_sep++; p_stop = 0;
          end else if (!p_stop) begin
            if (is_dig(c)) add_digit(p_sub, c, p_sub == 0 ? 9999 : 255);
            else p_stop = 1;
          end
        end
        1: begin
          if (c == CH_COLON && p_sub < 2) begin
            p_sub++; p_sep++; p_stop = 0;
          end else if (c == CH_DOT && p_sub == 2) begin
            p_sub = 3; p_stop = 0;
          end else if (!p_stop) begin
            if (is_dig(c)) add_digit(3 + p_sub, c, 65535);
            else p_stop = 1;
          end
        end
        2, 3, 4, 5: begin
          k = p_col - 2;
          if (!p_stop) begin
            if (c == CH_MINUS && p_sub == 0) begin
              p_neg = 1; p_sub = 1;
            end else begin
              p_sub = 1;
              if (is_dig(c)) begin
                if (!p_frac) begin
                  p_acc[k] = sat47(p_acc[k] * 10 + (c - CH_ZERO) * ten_to(FRAC));
                end else if (p_fdig < FRAC) begin
                  p_fdig++;
                  p_acc[k] = sat47(p_acc[k] + (c - CH_ZERO) * ten_to(FRAC - p_fdig));
                end
              end else if (c == CH_DOT && !p_frac) begin
                p_frac = 1;
              end else begin
                p_stop = 1;
              end
            end
          end
        end
        6: begin
          if (!p_stop) begin
            if (is_dig(c)) begin
              p_flags = p_flags * 10 + (c - CH_ZERO);
              if (p_flags > 64'hFFFF_FFFF) p_flags = 64'hFFFF_FFFF;
            end else begin
              p_stop = 1;
            end
          end
        end
        default: ;
      endcase
      return;
    end
    p_lines++;
    if (p_start || p_skip) begin
      p_start = 1; p_skip = 0;
      clear_ln();
      return;
    end
    close_col();
    r = '{default: '0};
    r.line_number = p_lines;
    if (p_col < 3) begin
      r.status = ST_FEW;
    end else begin
      b = longint'({{16{p_acc[0][47]}}, p_acc[0][47:0]});
      a = longint'({{16{p_acc[1][47]}}, p_acc[1][47:0]});
      r.status = (b <= 0 || a <= 0) ? ST_NONPOS : (b > a ? ST_CROSSED : ST_OK);
      r.year = 14'(p_parts[0]); r.month = 8'(p_parts[1]); r.day = 8'(p_parts[2]);
      r.time_ms = 38'(((longint'(p_parts[3]) * 3600 + p_parts[4] * 60 + p_parts[5]) * 1000)
                      + p_parts[6]);
      r.bid = 48'(p_acc[0]); r.ask = 48'(p_acc[1]);
      r.last = 48'(p_acc[2]); r.volume = 48'(p_acc[3]);
      r.flags = 32'(p_flags);
    end
    p_start = 1; p_skip = 0;
    clear_ln();
    lines_due.insert(lines_due.size(), r);
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // Byte stream; every byte of it is driven and predicted in order.
  byte unsigned text [$];
  // Directed lines whose result is plain to see: (text, status, line, typed).
  typedef struct { string s; logic [1:0] st; int ln; bit typed; } row_t;

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
  endtask

  function automatic string rnd_num(int maxd);
    string s = "";
    int n = $urandom_range(0, maxd);
    for (int i = 0; i < n; i++) s = {s, string'(byte'(8'd48 + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rnd_price();
    string s = "";
    if ($urandom_range(0, 5) == 0) s = "-";
    s = {s, rnd_num($urandom_range(0, 3) == 0 ? 18 : 4)};
    if ($urandom_range(0, 2) != 0) s = {s, ".", rnd_num(9)};
    return s;
  endfunction

  function automatic string noisy(string s);
    // occasionally corrupt a byte with any value except newline
    if (s.len() > 0 && $urandom_range(0, 9) == 0) begin
      byte b = byte'($urandom_range(0, 255));
      if (b == 8'd10) b = 8'd13;
      s[$urandom_range(0, s.len() - 1)] = b;
    end
    return s;
  endfunction

  // Directed status expectations, checked against the predicted status on arrival.
  logic [1:0] typed_status [int];

  initial begin
    row_t rows [$];
    string s;
    rows.insert(rows.size(),
      row_t'{"2024.01.02\t09:30:00.5\t1.5\t2.5\t1.75\t100\t7\t9\n", ST_OK, 1, 1});
    rows.insert(rows.size(), row_t'{"\n", ST_OK, 0, 0});
    rows.insert(rows.size(), row_t'{"<comment line\n", ST_OK, 0, 0});
    rows.insert(rows.size(), row_t'{"2024.1.2\t1:2:3\t5\n", ST_FEW, 4, 1});
    rows.insert(rows.size(), row_t'{"x\n", ST_FEW, 5, 1});
    rows.insert(rows.size(), row_t'{"1.1.1\t0:0:0\t0\t1\n", ST_NONPOS, 6, 1});
    rows.insert(rows.size(), row_t'{"1.1.1\t0:0:0\t3\t2\n", ST_CROSSED, 7, 1});
    rows.insert(rows.size(), row_t'{"1.1.1\t0:0:0\t-1\t2\n", ST_NONPOS, 8, 1});
    rows.insert(rows.size(),
      row_t'{"99999.999.999\t99999:99999:99999.99999\t1\t1\t1\t1\t99999999999\n",
             ST_OK, 9, 1});
    rows.insert(rows.size(), row_t'{"2024\t12:30\t0.0000001\t1\n", ST_NONPOS, 10, 1});
    rows.insert(rows.size(),
      row_t'{"1.2.3.4\t1:2:3.4.5\t99999999999999999999\t99999999999999999999\n",
             ST_OK, 11, 1});
    rows.insert(rows.size(),
      row_t'{"-5.1\t1-2\t1.2.3\t4x\t-\t.5\t12a\tz\tq\tw\n", ST_OK, 12, 0});
    rows.insert(rows.size(), row_t'{"\r1.2.3\r\t1:2:3\r\t1\r\t2\r\n", ST_OK, 13, 0});
    rows.insert(rows.size(), row_t'{"1.1.1\t1:1:1\t1\t1\n", ST_OK, 14, 1});
    rows.insert(rows.size(), row_t'{"<\t1\t2\t3\t4\n", ST_OK, 0, 0});
    foreach (rows[i]) begin
      add_str(rows[i].s);
      if (rows[i].typed) typed_status[rows[i].ln] = rows[i].st;
    end
    // a run of all byte values but newline, ended by a newline
    for (int v = 0; v < 256; v++) if (v != 10) text.insert(text.size(), byte'(v));
    text.insert(text.size(), 8'd10);
    // random lines: mostly well formed, some noise
    while (text.size() < 1850) begin
      if ($urandom_range(0, 9) == 0) begin
        s = "";
        for (int i = $urandom_range(0, 12); i > 0; i--) begin
          byte b;
          b = byte'($urandom_range(0, 255));
          if (b != 8'd10) s = {s, string'(b)};
        end
      end else begin
        s = {rnd_num(5), ".", rnd_num(3), ".", rnd_num(3), "\t",
             rnd_num(6), ":", rnd_num(3), ":", rnd_num(3)};
        if ($urandom_range(0, 1)) s = {s, ".", rnd_num(6)};
        for (int c = $urandom_range(1, 8); c > 0; c--)
          s = {s, "\t", (c == 1 && $urandom_range(0, 1)) ? rnd_num(12) : rnd_price()};
        s = noisy(s);
        if ($urandom_range(0, 19) == 0) s = {"<", s};
      end
      add_str({s, "\n"});
    end
  end

  // Input driver: changes at the falling edge.
  int unsigned sent = 0;
  initial begin
    int gap;
    in_chan.valid = 1'b0;
    in_chan.ch = 8'd0;
    pred_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (sent < text.size()) begin
      gap = $urandom_range(0, 5);
      if (sent > 800 && sent < 1200) gap = 0;  // stretch with no gaps
      if (sent == 1500) begin
        // hold off until every pending line result is out
        in_chan.valid <= 1'b0;
        @(negedge clk);
        while (lines_due.size() != 0) @(negedge clk);
      end
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_chan.valid <= 1'b1;
      in_chan.ch <= text[sent];
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
      parse_byte(text[sent]);
      sent++;
      @(negedge clk);
    end
    in_chan.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result sink: random stalls, checked at the rising edge.
  int unsigned stall = 0;
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    line_res_t w;
    cycles <= cycles + 1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      stall = (cycles % 3000 < 400) ? 0 : $urandom_range(0, 5);
      if (lines_due.size() == 0) begin
        report("unexpected result", out_chan.line_number, 0);
      end else begin
        w = lines_due.pop_front();
        if (typed_status.exists(w.line_number) && typed_status[w.line_number] != w.status)
          report("typed status", w.status, typed_status[w.line_number]);
        if (out_chan.status !== w.status) report("status", out_chan.status, w.status);
        if (out_chan.line_number !== w.line_number)
          report("line_number", out_chan.line_number, w.line_number);
        if (out_chan.year !== w.year) report("year", out_chan.year, w.year);
        if (out_chan.month !== w.month) report("month", out_chan.month, w.month);
        if (out_chan.day !== w.day) report("day", out_chan.day, w.day);
        if (out_chan.time_ms !== w.time_ms) report("time_ms", out_chan.time_ms, w.time_ms);
        if (out_chan.bid !== w.bid) report("bid", out_chan.bid, w.bid);
        if (out_chan.ask !== w.ask) report("ask", out_chan.ask, w.ask);
        if (out_chan.last !== w.last) report("last", out_chan.last, w.last);
        if (out_chan.volume !== w.volume) report("volume", out_chan.volume, w.volume);
        if (out_chan.flags !== w.flags) report("flags", out_chan.flags, w.flags);
      end
    end
  end

  // End of run and watchdog.
  initial begin
    wait (sending_done);
    while (lines_due.size() != 0 && cycles < LIMIT) @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (50) @(posedge clk);
      if (errors == 0 && lines_due.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/tlp_pkg.sv
rtl/tlp_if.sv
rtl/tlp_parser.sv
rtl/tlp_finish.sv
rtl/tick_line_parser.sv
sim/tb.sv
